>>> src/fhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared types and constants for the single/half float converter.
// ----------------------------------------------------------------------------
package fhc_pkg;

   localparam logic OP_S2H = 1'b0;
   localparam logic OP_H2S = 1'b1;

   localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
   localparam logic [7:0]  EXP_S2H_SPEC  = 8'd255;
   localparam logic [23:0] ROUND_HALF    = 24'h001000;
   localparam logic [15:0] HALF_INF      = 16'h7c00;

   typedef struct packed {
      logic        op;
      logic        sign;
      logic [7:0]  exp;
      logic [22:0] man;
   } stage1_type;

endpackage : fhc_pkg
`default_nettype wire

>>> src/float_half_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_half_converter
// Converts IEEE binary32 to binary16 (op 0) and binary16 to binary32 (op 1).
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the input stream: tuser carries op, tdata carries value_bits.
//   rsp_* is the result stream: tdata carries result_bits, one beat per
//   request beat, in order.
//   A request beat passes the stage 1, 2 and 3 registers before it leaves.
//   Throughput is one beat per cycle while rsp_tready is high, since every
//   stage can take a new beat in the cycle it hands one on.
//   Stage 1 decodes fields and computes the shift / leading-zero count,
//   stage 2 aligns the mantissa and packs the exact cases, stage 3 rounds,
//   packs and holds the output register.
//   Reset clears all valid bits; no result is pending afterwards.
//   When the receiver stalls, a stage advances only if the stage after it is
//   empty or moving, so beats hold in place and none is lost or repeated.
//   req_tready falls only when all three stages are full and rsp_tready is low.
// ----------------------------------------------------------------------------
module float_half_converter
   import fhc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value_bits
   input  wire logic        req_tuser,   // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [31:0] result_bits
);

   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   assign adv3       = !v3_ff || rsp_tready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1;
   assign rsp_tvalid = v3_ff;

   // stage 1: decode
   logic        op1_ff, sign1_ff, zero1_ff, spec1_ff, norm1_ff;
   logic [4:0]  sh1_ff;
   logic [23:0] man1_ff;
   logic [7:0]  exp1_ff;

   logic        sign1_in, zero1_in, spec1_in, norm1_in;
   logic [4:0]  sh1_in;
   logic [23:0] man1_in;
   logic [7:0]  exp1_in;

   always_comb begin
      logic [7:0] e8;
      logic [9:0] hm;
      logic [4:0] he;
      logic [3:0] lz;
      e8 = req_tdata[30:23];
      hm = req_tdata[9:0];
      he = req_tdata[14:10];
      lz = 4'd0;
      sign1_in = 1'b0;
      zero1_in = 1'b0;
      spec1_in = 1'b0;
      norm1_in = 1'b0;
      sh1_in   = 5'd0;
      man1_in  = 24'd0;
      exp1_in  = 8'd0;
      if (req_tuser == OP_S2H) begin
         sign1_in = req_tdata[31];
         man1_in  = {1'b0, req_tdata[22:0]};
         exp1_in  = e8;
         if (e8 == EXP_S2H_SPEC) begin
            spec1_in = 1'b1;
         end else if (e8 <= EXP_BIAS_DIFF) begin
            // half denormal: shift = 113 - e8
            if (e8 < 8'd89) begin
               zero1_in = 1'b1;
            end else begin
               sh1_in  = 5'(8'd113 - e8);
               man1_in = {1'b1, req_tdata[22:0]};
            end
         end else begin
            norm1_in = 1'b1;
         end
      end else begin
         sign1_in = req_tdata[15];
         man1_in  = {14'd0, hm};
         exp1_in  = {3'd0, he};
         for (int i = 9; i >= 0; i--) begin
            if (hm[i] && lz == 4'd0 && hm[9:0] >> (i + 1) == 10'd0) begin
               lz = 4'(10 - i);
            end
         end
         sh1_in   = {1'b0, lz};
         zero1_in = (he == 5'd0) && (hm == 10'd0);
         spec1_in = (he == 5'd31);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= req_tvalid;
      end
      if (adv1) begin
         op1_ff   <= req_tuser;
         sign1_ff <= sign1_in;
         zero1_ff <= zero1_in;
         spec1_ff <= spec1_in;
         norm1_ff <= norm1_in;
         sh1_ff   <= sh1_in;
         man1_ff  <= man1_in;
         exp1_ff  <= exp1_in;
      end
   end

   // stage 2: align
   logic [31:0] pre2_in, pre2_ff;
   logic [23:0] man2_in, man2_ff;
   logic [7:0]  exp2_in, exp2_ff;
   logic        norm2_in, norm2_ff;
   logic        den2_in, den2_ff;

   always_comb begin
      logic [7:0]  e;
      logic [9:0]  hm;
      logic [9:0]  sm;
      pre2_in  = 32'd0;
      man2_in  = 24'd0;
      exp2_in  = 8'd0;
      norm2_in = 1'b0;
      den2_in  = 1'b0;
      e  = 8'd0;
      hm = 10'd0;
      sm = 10'd0;
      if (op1_ff == OP_S2H) begin
         pre2_in[15] = sign1_ff;
         if (zero1_ff) begin
            pre2_in[14:0] = 15'd0;
         end else if (spec1_ff) begin
            hm = man1_ff[22:13];
            pre2_in[14:0] = 15'(HALF_INF) | 15'(hm);
            if (man1_ff[22:0] != 23'd0 && hm == 10'd0) pre2_in[0] = 1'b1;
         end else if (norm1_ff) begin
            norm2_in = 1'b1;
            man2_in  = man1_ff;
            exp2_in  = exp1_ff - EXP_BIAS_DIFF;
         end else begin
            den2_in = 1'b1;
            man2_in = man1_ff >> sh1_ff;
         end
      end else begin
         pre2_in[31] = sign1_ff;
         if (zero1_ff) begin
            pre2_in[30:0] = 31'd0;
         end else if (spec1_ff) begin
            pre2_in[30:0] = {8'hff, man1_ff[9:0], 13'd0};
         end else if (exp1_ff == 8'd0) begin
            sm = man1_ff[9:0] << sh1_ff;
            e  = 8'd113 - {3'd0, sh1_ff};
            pre2_in[30:0] = {e, sm, 13'd0};
         end else begin
            pre2_in[30:0] = {exp1_ff + EXP_BIAS_DIFF, man1_ff[9:0], 13'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         pre2_ff  <= pre2_in;
         man2_ff  <= man2_in;
         exp2_ff  <= exp2_in;
         norm2_ff <= norm2_in;
         den2_ff  <= den2_in;
      end
   end

   // stage 3: round and pack
   logic [31:0] res3_in, res3_ff;

   always_comb begin
      logic [23:0] m;
      logic [7:0]  e;
      m = man2_ff + ROUND_HALF;
      e = exp2_ff;
      res3_in = pre2_ff;
      if (norm2_ff) begin
         if (m[23]) begin
            m = 24'd0;
            e = e + 8'd1;
         end
         if (e >= 8'd31) res3_in[14:0] = 15'(HALF_INF);
         else res3_in[14:0] = {e[4:0], m[22:13]};
      end else if (den2_ff) begin
         res3_in[14:0] = {4'd0, m[23:13]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff <= v2_ff;
      end
      if (adv3) res3_ff <= res3_in;
   end

   assign rsp_tdata = res3_ff;

endmodule : float_half_converter
`default_nettype wire
